[src/hso_pkg.sv]
// Shared types, constants and helper functions for the HMAC-SHA1 one-time-password checker.
package hso_pkg;

    typedef logic [0:15][31:0] t_blk;
    typedef logic [0:4][31:0]  t_state;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    localparam t_state HSO_IV = {32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE,
                                 32'h1032_5476, 32'hC3D2_E1F0};

    localparam logic [7:0]  HSO_IPAD       = 8'h36;
    localparam logic [7:0]  HSO_OPAD       = 8'h5C;
    localparam logic [31:0] HSO_PAD_WORD   = 32'h8000_0000;
    localparam logic [31:0] HSO_INNER_BITS = 32'd576;
    localparam logic [31:0] HSO_OUTER_BITS = 32'd672;
    localparam logic [5:0]  HSO_STEP       = 6'd30;
    localparam logic [20:0] HSO_MODULUS    = 21'd1000000;
    localparam logic [30:0] HSO_BIN_MASK   = 31'h7FFF_FFFF;

    function automatic logic [31:0] hso_f(input int idx, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (idx < 20) begin
            f = (b & c) | (~b & d);
        end else if (idx < 40) begin
            f = b ^ c ^ d;
        end else if (idx < 60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic logic [31:0] hso_k(input int idx);
        logic [31:0] k;
        if (idx < 20) begin
            k = 32'h5A82_7999;
        end else if (idx < 40) begin
            k = 32'h6ED9_EBA1;
        end else if (idx < 60) begin
            k = 32'h8F1B_BCDC;
        end else begin
            k = 32'hCA62_C1D6;
        end
        return k;
    endfunction

    // First HMAC block: key zero-padded to 64 bytes, every byte xored with the pad.
    function automatic t_blk hso_key_blk(input logic [79:0] key, input logic [7:0] pad);
        t_blk blk;
        for (int j = 0; j < 16; j++) begin
            blk[j] = {4{pad}};
        end
        blk[0] = key[79:48] ^ {4{pad}};
        blk[1] = key[47:16] ^ {4{pad}};
        blk[2] = {key[15:0], 16'h0000} ^ {4{pad}};
        return blk;
    endfunction

    // Eight restoring-division steps by 30: returns {quotient byte, remainder}.
    function automatic logic [12:0] hso_div30_byte(input logic [4:0] rem,
                                                   input logic [7:0] bits);
        logic [4:0] r;
        logic [5:0] t;
        logic [7:0] q;
        r = rem;
        q = '0;
        for (int j = 7; j >= 0; j--) begin
            t = {r, bits[j]};
            if (t >= HSO_STEP) begin
                t    = t - HSO_STEP;
                q[j] = 1'b1;
            end
            r = t[4:0];
        end
        return {q, r};
    endfunction

    // Four remainder steps modulo one million.
    function automatic logic [19:0] hso_mod_nib(input logic [19:0] rem,
                                                input logic [3:0] bits);
        logic [20:0] t;
        logic [19:0] r;
        r = rem;
        for (int j = 3; j >= 0; j--) begin
            t = {r, bits[j]};
            if (t >= HSO_MODULUS) begin
                t = t - HSO_MODULUS;
            end
            r = t[19:0];
        end
        return r;
    endfunction

endpackage

[src/hso_compress.sv]
// Fully unrolled SHA-1 compression: an input register stage, one register stage per round and a final add stage.
module hso_compress
    import hso_pkg::*;
#(
    parameter int SIDE_W = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_state            i_h,
    input  t_blk              i_blk,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output t_state            o_h,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_v    [0:80];
    t_state            r_s    [0:80];
    t_state            r_h    [0:80];
    t_blk              r_w    [0:80];
    logic [SIDE_W-1:0] r_side [0:80];
    logic              r_o_v;
    t_state            r_o_h;
    logic [SIDE_W-1:0] r_o_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s[0]    <= i_h;
            r_h[0]    <= i_h;
            r_w[0]    <= i_blk;
            r_side[0] <= i_side;
        end
    end

    for (genvar i = 0; i < 80; i++) begin : g_round
        logic [31:0] n_f;
        logic [31:0] n_t;
        logic [31:0] n_x;
        t_blk        n_w;
        t_state      n_s;

        assign n_f = hso_f(i, r_s[i][1], r_s[i][2], r_s[i][3]);
        assign n_t = {r_s[i][0][26:0], r_s[i][0][31:27]} + n_f + r_s[i][4]
                     + hso_k(i) + r_w[i][0];
        assign n_x = r_w[i][13] ^ r_w[i][8] ^ r_w[i][2] ^ r_w[i][0];

        always_comb begin
            for (int j = 0; j < 15; j++) begin
                n_w[j] = r_w[i][j+1];
            end
            n_w[15] = {n_x[30:0], n_x[31]};
            n_s[0]  = n_t;
            n_s[1]  = r_s[i][0];
            n_s[2]  = {r_s[i][1][1:0], r_s[i][1][31:2]};
            n_s[3]  = r_s[i][2];
            n_s[4]  = r_s[i][3];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[i+1]    <= n_s;
                r_w[i+1]    <= n_w;
                r_h[i+1]    <= r_h[i];
                r_side[i+1] <= r_side[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_o_v <= r_v[80];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 5; j++) begin
                r_o_h[j] <= r_h[80][j] + r_s[80][j];
            end
            r_o_side <= r_side[80];
        end
    end

    assign o_valid = r_o_v;
    assign o_h     = r_o_h;
    assign o_side  = r_o_side;

endmodule

[src/hmac_sha1_otp_check.sv]
// Top level of the HMAC-SHA1 HOTP/TOTP code checker.
// Accepts one transaction per clock while o_stall is low and returns one result per
// transaction, in order. Each transaction passes through an input register, an 8-stage
// divide-by-30 for time mode, the four unrolled SHA-1 compressions (82 register stages
// each), a truncation stage, an 8-stage modulo-one-million reduction and the output
// register. A result waiting on a stalled output does not stop new transactions while
// the last pipeline stage is empty. The user must write the 80-bit key through the
// config port only while the block is idle; the block itself does not enforce this.
module hmac_sha1_otp_check
    import hso_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [63:0] i_counter_or_time,
    input  logic [19:0] i_candidate_code,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [19:0] o_otp_value,
    output logic        o_is_match
);

    logic [15:0] r_key_high;
    logic [63:0] r_key_low;
    logic [79:0] w_key;
    logic        w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_HIGH: r_key_high <= i_cfg_wdata[15:0];
                CFG_KEY_LOW:  r_key_low  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_key = {r_key_high, r_key_low};

    // ---- divide by 30, one byte per stage ----
    logic        r_dv_v    [0:8];
    logic        r_dv_mode [0:8];
    logic [63:0] r_dv_val  [0:8];
    logic [63:0] r_dv_q    [0:8];
    logic [4:0]  r_dv_rem  [0:8];
    logic [19:0] r_dv_cand [0:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_mode[0] <= i_opcode;
            r_dv_val[0]  <= i_counter_or_time;
            r_dv_q[0]    <= '0;
            r_dv_rem[0]  <= '0;
            r_dv_cand[0] <= i_candidate_code;
        end
    end

    for (genvar k = 0; k < 8; k++) begin : g_div
        logic [12:0] n_step;

        assign n_step = hso_div30_byte(r_dv_rem[k], r_dv_val[k][63-8*k -: 8]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_mode[k+1] <= r_dv_mode[k];
                r_dv_val[k+1]  <= r_dv_val[k];
                r_dv_q[k+1]    <= {r_dv_q[k][55:0], n_step[12:5]};
                r_dv_rem[k+1]  <= n_step[4:0];
                r_dv_cand[k+1] <= r_dv_cand[k];
            end
        end
    end

    logic [63:0] w_factor;
    assign w_factor = r_dv_mode[8] ? r_dv_q[8] : r_dv_val[8];

    // ---- inner hash ----
    logic        w_a_v;
    t_state      w_a_h;
    logic [83:0] w_a_side;
    t_blk        n_blk_b;
    logic        w_b_v;
    t_state      w_b_h;
    logic [19:0] w_b_side;

    hso_compress #(.SIDE_W(84)) u_inner1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_dv_v[8]),
        .i_h     (HSO_IV),
        .i_blk   (hso_key_blk(w_key, HSO_IPAD)),
        .i_side  ({w_factor, r_dv_cand[8]}),
        .o_valid (w_a_v),
        .o_h     (w_a_h),
        .o_side  (w_a_side)
    );

    always_comb begin
        n_blk_b     = '0;
        n_blk_b[0]  = w_a_side[83:52];
        n_blk_b[1]  = w_a_side[51:20];
        n_blk_b[2]  = HSO_PAD_WORD;
        n_blk_b[15] = HSO_INNER_BITS;
    end

    hso_compress #(.SIDE_W(20)) u_inner2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_a_v),
        .i_h     (w_a_h),
        .i_blk   (n_blk_b),
        .i_side  (w_a_side[19:0]),
        .o_valid (w_b_v),
        .o_h     (w_b_h),
        .o_side  (w_b_side)
    );

    // ---- outer hash ----
    logic         w_c_v;
    t_state       w_c_h;
    logic [179:0] w_c_side;
    t_blk         n_blk_d;
    logic         w_d_v;
    t_state       w_d_h;
    logic [19:0]  w_d_side;

    hso_compress #(.SIDE_W(180)) u_outer1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_b_v),
        .i_h     (HSO_IV),
        .i_blk   (hso_key_blk(w_key, HSO_OPAD)),
        .i_side  ({w_b_h, w_b_side}),
        .o_valid (w_c_v),
        .o_h     (w_c_h),
        .o_side  (w_c_side)
    );

    always_comb begin
        n_blk_d = '0;
        for (int j = 0; j < 5; j++) begin
            n_blk_d[j] = w_c_side[179-32*j -: 32];
        end
        n_blk_d[5]  = HSO_PAD_WORD;
        n_blk_d[15] = HSO_OUTER_BITS;
    end

    hso_compress #(.SIDE_W(20)) u_outer2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_c_v),
        .i_h     (w_c_h),
        .i_blk   (n_blk_d),
        .i_side  (w_c_side[19:0]),
        .o_valid (w_d_v),
        .o_h     (w_d_h),
        .o_side  (w_d_side)
    );

    // ---- dynamic truncation ----
    logic [159:0] w_mac;
    logic [159:0] w_mac_sh;

    assign w_mac    = w_d_h;
    assign w_mac_sh = w_mac << {w_mac[3:0], 3'b000};

    // ---- modulo one million, one nibble per stage ----
    logic        r_md_v    [0:8];
    logic [31:0] r_md_bin  [0:8];
    logic [19:0] r_md_rem  [0:8];
    logic [19:0] r_md_cand [0:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_md_v[0] <= 1'b0;
        end else if (w_en) begin
            r_md_v[0] <= w_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_md_bin[0]  <= {1'b0, w_mac_sh[158:128] & HSO_BIN_MASK};
            r_md_rem[0]  <= '0;
            r_md_cand[0] <= w_d_side;
        end
    end

    for (genvar k = 0; k < 8; k++) begin : g_mod
        logic [19:0] n_rem;

        assign n_rem = hso_mod_nib(r_md_rem[k], r_md_bin[k][31-4*k -: 4]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_md_v[k+1] <= 1'b0;
            end else if (w_en) begin
                r_md_v[k+1] <= r_md_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_md_bin[k+1]  <= r_md_bin[k];
                r_md_rem[k+1]  <= n_rem;
                r_md_cand[k+1] <= r_md_cand[k];
            end
        end
    end

    // ---- output register ----
    logic        r_out_v;
    logic [19:0] r_out_otp;
    logic        r_out_match;
    logic        w_out_load;

    // Advance everything unless a finished result would be pushed into a held output.
    assign w_en       = !(r_md_v[8] && r_out_v && i_stall);
    assign w_out_load = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_load) begin
            r_out_v <= r_md_v[8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_otp   <= r_md_rem[8];
            r_out_match <= (r_md_rem[8] == r_md_cand[8]);
        end
    end

    assign o_stall     = !w_en;
    assign o_valid     = r_out_v;
    assign o_otp_value = r_out_otp;
    assign o_is_match  = r_out_match;

endmodule

[src/hso_checker.sv]
// Port-level checker for the OTP checker, bound to the top level.
module hso_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [19:0] o_otp_value,
    input logic        o_is_match
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_otp_value) && $stable(o_is_match))
        else $error("result changed while stalled");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_otp_value < 20'd1000000)
        else $error("code out of range");

    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && i_stall) |-> !o_stall)
        else $error("input stalled while output is free");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind hmac_sha1_otp_check hso_checker u_hso_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the HMAC-SHA1 HOTP/TOTP code checker.
`timescale 1ns / 100ps

class otp_scoreboard;
    bit [15:0]   key_hi;
    bit [63:0]   key_lo;
    bit [19:0]   want_code[$];
    bit          want_match[$];
    int          n_errors;
    int          n_checked;
    int          n_hits;

    function automatic bit [31:0] rol(bit [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void compress(ref bit [31:0] h[5], input bit [7:0] blk[64]);
        bit [31:0] w[80];
        bit [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
    endfunction

    // Hash a message of 72 or 84 bytes: always two blocks after padding.
    function automatic void digest(input bit [7:0] msg[$], output bit [7:0] dig[20]);
        bit [7:0]  buf0[64];
        bit [7:0]  buf1[64];
        bit [7:0]  all[128];
        bit [31:0] h[5];
        bit [63:0] nbits;
        h = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
        nbits = msg.size() * 8;
        foreach (all[i]) all[i] = 8'h00;
        foreach (msg[i]) all[i] = msg[i];
        all[msg.size()] = 8'h80;
        for (int i = 0; i < 8; i++) all[127-i] = nbits[8*i +: 8];
        for (int i = 0; i < 64; i++) begin
            buf0[i] = all[i]; buf1[i] = all[64+i];
        end
        compress(h, buf0);
        compress(h, buf1);
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 4; j++) dig[4*i+j] = h[i][31-8*j -: 8];
    endfunction

    function automatic bit [19:0] code_for(bit [63:0] factor);
        bit [79:0] key;
        bit [7:0]  kb;
        bit [7:0]  inner_msg[$];
        bit [7:0]  outer_msg[$];
        bit [7:0]  inner[20];
        bit [7:0]  mac[20];
        bit [3:0]  off;
        bit [31:0] bin;
        key = {key_hi, key_lo};
        for (int i = 0; i < 64; i++) begin
            kb = (i < 10) ? key[79-8*i -: 8] : 8'h00;
            inner_msg.push_back(kb ^ 8'h36);
            outer_msg.push_back(kb ^ 8'h5C);
        end
        for (int i = 0; i < 8; i++) inner_msg.push_back(factor[63-8*i -: 8]);
        digest(inner_msg, inner);
        foreach (inner[i]) outer_msg.push_back(inner[i]);
        digest(outer_msg, mac);
        off = mac[19][3:0];
        bin = {1'b0, mac[off][6:0], mac[off+1], mac[off+2], mac[off+3]};
        return 20'(bin % 1000000);
    endfunction

    function void note_request(bit op, bit [63:0] value, bit [19:0] cand);
        bit [19:0] code;
        code = code_for(op ? value / 64'd30 : value);
        want_code.push_back(code);
        want_match.push_back(code == cand);
    endfunction

    function void check_result(bit [19:0] code, bit hit);
        bit [19:0] ec;
        bit        em;
        if (want_code.size() == 0) begin
            $error("unexpected result: otp_value %0d is_match %0b", code, hit);
            n_errors++;
            return;
        end
        ec = want_code.pop_front();
        em = want_match.pop_front();
        n_checked++;
        if (hit) n_hits++;
        if (code !== ec) begin
            $error("otp_value: expected %0d, actual %0d", ec, code);
            n_errors++;
        end
        if (hit !== em) begin
            $error("is_match: expected %0b, actual %0b", em, hit);
            n_errors++;
        end
    endfunction
endclass

module testbench
    import hso_pkg::*;
();

    localparam int LATENCY   = 347;
    localparam int N_RANDOM  = 1080;
    localparam int MAX_CYCLE = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [63:0] i_cfg_wdata;
    logic        i_valid;
    logic        o_stall;
    logic        i_opcode;
    logic [63:0] i_counter_or_time;
    logic [19:0] i_candidate_code;
    logic        o_valid;
    logic        i_stall;
    logic [19:0] o_otp_value;
    logic        o_is_match;

    otp_scoreboard otp_sb;
    int  n_cycles;
    int  n_sent;
    bit  quiet_sender;
    bit  quiet_receiver;
    bit  hold_off;

    hmac_sha1_otp_check dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > MAX_CYCLE) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // Score every accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            otp_sb.check_result(o_otp_value, o_is_match);
    end

    // Receiver stall: random, quiet stretch, or a long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else if (hold_off) i_stall <= 1'b1;
        else if (quiet_receiver) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < 6);
    end

    task automatic write_reg(bit idx, bit [63:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_KEY_HIGH) otp_sb.key_hi = val[15:0];
        else otp_sb.key_lo = val;
    endtask

    // Offer one transaction, idling first at random; return at the falling edge after accept.
    task automatic send_request(bit op, bit [63:0] value, bit [19:0] cand);
        while (!quiet_sender && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_opcode          <= op;
        i_counter_or_time <= value;
        i_candidate_code  <= cand;
        do @(posedge i_clk); while (o_stall);
        otp_sb.note_request(op, value, cand);
        n_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid right away so the last transaction is not offered twice.
    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (otp_sb.want_code.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Candidate: the true code in 35 percent of draws so matches happen, else out of range or random.
    function automatic bit [19:0] pick_candidate(bit op, bit [63:0] value);
        int r;
        r = $urandom_range(99);
        if (r < 35) return otp_sb.code_for(op ? value / 64'd30 : value);
        if (r < 45) return 20'(999999 + $urandom_range(1, 48575));
        return 20'($urandom_range(999999));
    endfunction

    task automatic random_phase(int count);
        bit        op;
        bit [63:0] value;
        for (int i = 0; i < count; i++) begin
            op = 1'($urandom_range(1));
            case ($urandom_range(3))
                0: value = 64'($urandom_range(1000));
                1: value = 64'd1_700_000_000 + 64'($urandom_range(100000));
                default: value = rand64();
            endcase
            send_request(op, value, pick_candidate(op, value));
        end
    endtask

    initial begin
        otp_sb         = new();
        n_cycles       = 0;
        n_sent         = 0;
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
        hold_off       = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_KEY_HIGH;
        i_cfg_wdata    = '0;
        i_valid        = 1'b0;
        i_opcode       = 1'b0;
        i_counter_or_time = '0;
        i_candidate_code  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset key of zeros, then the RFC test key "12345678901234567890" tail.
        send_request(1'b0, 64'd0, 20'd0);
        drain();
        write_reg(CFG_KEY_HIGH, 64'h3132);
        write_reg(CFG_KEY_LOW,  64'h3334_3536_3738_3930);
        send_request(1'b0, 64'd0, 20'd0);
        send_request(1'b0, 64'd1, 20'd0);
        send_request(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 20'hFFFFF);
        send_request(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 20'd999999);
        send_request(1'b1, 64'd29, 20'd0);
        send_request(1'b1, 64'd30, 20'd1000000);
        send_request(1'b1, 64'd59, 20'd0);
        send_request(1'b1, 64'd1_111_111_109, 20'd0);
        send_request(1'b0, 64'd5, otp_sb.code_for(64'd5));
        send_request(1'b1, 64'd90, otp_sb.code_for(64'd3));
        send_request(1'b0, 64'h8000_0000_0000_0000, 20'h80000);
        send_request(1'b0, 64'h5555_5555_5555_5555, 20'h55555);
        send_request(1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 20'hAAAAA);
        drain();
        write_reg(CFG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_KEY_LOW,  64'hFFFF_FFFF_FFFF_FFFF);
        send_request(1'b0, 64'd0, 20'd0);
        send_request(1'b1, 64'd12345678, 20'd0);
        drain();

        // Random keys per phase; the first phase runs without idling on either side.
        // The hold-off phase is long enough that the sender is still offering when
        // the pipeline backs up.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_KEY_HIGH, rand64());
            write_reg(CFG_KEY_LOW, rand64());
            quiet_sender   = (ph == 0);
            quiet_receiver = (ph == 0);
            if (ph == 2) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (600) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            random_phase((ph == 2) ? N_RANDOM - 5 * (N_RANDOM / 9) : N_RANDOM / 9);
            drain();
        end
        repeat (LATENCY + 20) @(negedge i_clk);

        $display("Sent %0d requests, checked %0d results (%0d matches), several keys.",
                 n_sent, otp_sb.n_checked, otp_sb.n_hits);
        if (otp_sb.n_errors == 0 && otp_sb.want_code.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d errors, %0d results missing", otp_sb.n_errors,
                     otp_sb.want_code.size());
            $display("Verification failed");
        end
        $finish;
    end
endmodule
